// File: src/ita_pkg.sv
package ita_pkg;

  localparam int VALUE_BITS_DEF = 64;

  localparam logic [1:0] ACT_HEX    = 2'd1;
  localparam logic [1:0] ACT_BINARY = 2'd2;

  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_ONE   = 8'h31;
  localparam logic [7:0] ASC_NINE  = 8'h39;
  localparam logic [7:0] ASC_A     = 8'h41;
  localparam logic [7:0] ASC_F     = 8'h46;
  localparam logic [7:0] ASC_MINUS = 8'h2D;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  action;
    logic        is_signed;
    logic [6:0]  digit_width;
  } item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_t;

  typedef enum logic [1:0] {
    FMT_DEC,
    FMT_HEX,
    FMT_BIN
  } fmt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CONVERT,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic dab_step;
    logic skip_step;
    logic emit_sign;
    logic emit_char;
  } cmd_t;

  typedef struct packed {
    fmt_t fmt;
    logic neg;
    logic cnt_zero;
    logic cnt_one;
    logic top_zero;
    logic out_free;
  } stat_t;

endpackage

// File: src/ita_ctrl.sv
module ita_ctrl import ita_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat.fmt == FMT_DEC) state_next = ST_CONVERT;
        else if (stat.cnt_zero) state_next = ST_IDLE;
        else state_next = ST_EMIT;
      end
      ST_CONVERT: begin
        if (stat.cnt_one) state_next = stat.neg ? ST_SIGN : ST_SKIP;
      end
      ST_SIGN: begin
        if (stat.out_free) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (!(stat.top_zero && !stat.cnt_one)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free && stat.cnt_one) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = !rst;
        cmd.load   = item_valid && !rst;
      end
      ST_CONVERT: begin
        cmd.dab_step = 1'b1;
      end
      ST_SIGN: begin
        cmd.emit_sign = stat.out_free;
      end
      ST_SKIP: begin
        cmd.skip_step = stat.top_zero && !stat.cnt_one;
      end
      ST_EMIT: begin
        cmd.emit_char = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: src/ita_dp.sv
module ita_dp import ita_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  item_t item,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  text_valid,
  input  logic  text_ready,
  output text_t text
);

  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int BCD_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCD_W      = 4 * BCD_DIGITS;

  logic [VALUE_BITS-1:0] work;
  logic [BCD_W-1:0]      bcd;
  logic [CNT_W-1:0]      cnt;
  fmt_t                  fmt;
  logic                  neg;

  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] mag;
  logic                  sign_in;
  logic [6:0]            wsat;
  logic [CNT_W-1:0]      shamt;
  fmt_t                  fmt_in;
  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_dig;
  logic [3:0]            top_nib;
  logic [7:0]            char_sel;
  logic                  out_free;

  assign v       = item.value[VALUE_BITS-1:0];
  assign sign_in = item.is_signed && v[VALUE_BITS-1];
  assign mag     = sign_in ? (~v + 1'b1) : v;
  assign wsat    = (item.digit_width > 7'(VALUE_BITS)) ? 7'(VALUE_BITS) : item.digit_width;
  assign shamt   = CNT_W'(VALUE_BITS) - CNT_W'(wsat);

  always_comb begin
    case (item.action)
      ACT_HEX:    fmt_in = FMT_HEX;
      ACT_BINARY: fmt_in = FMT_BIN;
      default:    fmt_in = FMT_DEC;
    endcase
  end

  // shift-and-add-3 correction per BCD digit
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign top_dig = bcd[BCD_W-1 -: 4];
  assign top_nib = work[VALUE_BITS-1 -: 4];

  always_comb begin
    case (fmt)
      FMT_HEX: begin
        char_sel = (top_nib < 4'd10) ? ASC_ZERO + {4'b0, top_nib}
                                     : ASC_A + {4'b0, top_nib - 4'd10};
      end
      FMT_BIN: char_sel = work[VALUE_BITS-1] ? ASC_ONE : ASC_ZERO;
      default: char_sel = ASC_ZERO + {4'b0, top_dig};
    endcase
  end

  assign out_free      = !text_valid || text_ready;
  assign stat.fmt      = fmt;
  assign stat.neg      = neg;
  assign stat.cnt_zero = (cnt == '0);
  assign stat.cnt_one  = (cnt == CNT_W'(1));
  assign stat.top_zero = (top_dig == 4'd0);
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fmt <= fmt_in;
      neg <= sign_in;
      bcd <= '0;
      case (fmt_in)
        FMT_HEX: begin
          work <= v << shamt;
          cnt  <= CNT_W'(wsat >> 2);
        end
        FMT_BIN: begin
          work <= v << shamt;
          cnt  <= CNT_W'(wsat);
        end
        default: begin
          work <= mag;
          cnt  <= CNT_W'(VALUE_BITS);
        end
      endcase
    end else if (cmd.dab_step) begin
      bcd  <= {bcd_adj[BCD_W-2:0], work[VALUE_BITS-1]};
      work <= work << 1;
      cnt  <= stat.cnt_one ? CNT_W'(BCD_DIGITS) : cnt - 1'b1;
    end else if (cmd.skip_step) begin
      bcd <= bcd << 4;
      cnt <= cnt - 1'b1;
    end else if (cmd.emit_char) begin
      case (fmt)
        FMT_HEX: work <= work << 4;
        FMT_BIN: work <= work << 1;
        default: bcd  <= bcd << 4;
      endcase
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      text <= '{character: ASC_MINUS, last: 1'b0};
    end else if (cmd.emit_char) begin
      text <= '{character: char_sel, last: stat.cnt_one};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_char) begin
      text_valid <= 1'b1;
    end else if (text_ready) begin
      text_valid <= 1'b0;
    end
  end

endmodule

// File: src/integer_to_ascii_formatter_unit.sv
// channel | handshake               | payload
// item    | item_valid / item_ready | item_t : value, action, is_signed, digit_width
// text    | text_valid / text_ready | text_t : character, last
//
// One value at a time. Hex and binary: load and dispatch, then one character
// per cycle while text is not stalled; a width of no digits gives no text.
// Decimal: load, dispatch, a shift-and-add-3 conversion over VALUE_BITS bits,
// a minus sign if negative, leading-zero skip, then one digit per unstalled cycle.
// Reset (rst, synchronous) returns to idle and drops text_valid. A stalled
// text transfer holds the character in the output register and pauses output.
module integer_to_ascii_formatter_unit import ita_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  text_valid,
  input  logic  text_ready,
  output text_t text
);

  cmd_t  cmd;
  stat_t stat;

  ita_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ita_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cmd        (cmd),
    .stat       (stat),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

endmodule

// File: src/ita_checker.sv
module ita_checker import ita_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  item_valid,
  input logic  item_ready,
  input logic  text_valid,
  input logic  text_ready,
  input text_t text
);

  a_reset_clears_text: assert property (@(posedge clk) rst |=> !text_valid)
    else $error("text_valid not cleared by reset");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken before the first was formatted");

  a_text_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(text))
    else $error("stalled text transfer changed");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> (text.character == ASC_MINUS)
                || (text.character >= ASC_ZERO && text.character <= ASC_NINE)
                || (text.character >= ASC_A && text.character <= ASC_F))
    else $error("character outside the output alphabet");

endmodule

bind integer_to_ascii_formatter_unit ita_checker u_chk (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ita_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  localparam logic [1:0] ACT_DECIMAL = 2'd0;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_ITEMS = 100;

  class char_scoreboard;
    text_t expected_chars[$];
    int errors;
    int items_noted;
    int silent_items;
    int chars_checked;

    function new();
      errors = 0;
      items_noted = 0;
      silent_items = 0;
      chars_checked = 0;
    endfunction

    // Expected text of one value, pushed in output order.
    function void note_item(item_t it);
      logic [63:0] v;
      logic [63:0] mag;
      logic [3:0] nib;
      logic [7:0] line_chars[$];
      logic [7:0] rev[$];
      int unsigned w;
      bit neg;
      text_t t;
      v = it.value & ({64{1'b1}} >> (64 - VALUE_BITS));
      w = 32'(it.digit_width);
      if (w > VALUE_BITS) w = VALUE_BITS;
      case (it.action)
        ACT_HEX: begin
          for (int unsigned i = 0; i < w / 4; i++) begin
            nib = 4'(v >> (w - 4 - 4 * i));
            line_chars.push_back(nib < 10 ? ASC_ZERO + nib : ASC_A + (nib - 4'd10));
          end
        end
        ACT_BINARY: begin
          for (int unsigned i = 0; i < w; i++) begin
            line_chars.push_back(v[w - 1 - i] ? ASC_ONE : ASC_ZERO);
          end
        end
        default: begin
          neg = it.is_signed && v[VALUE_BITS - 1];
          mag = neg ? ((~v + 64'd1) & ({64{1'b1}} >> (64 - VALUE_BITS))) : v;
          do begin
            rev.push_back(ASC_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
          end while (mag != 0);
          if (neg) line_chars.push_back(ASC_MINUS);
          while (rev.size() > 0) line_chars.push_back(rev.pop_back());
        end
      endcase
      items_noted++;
      if (line_chars.size() == 0) silent_items++;
      foreach (line_chars[i]) begin
        t.character = line_chars[i];
        t.last = (i == line_chars.size() - 1);
        expected_chars.push_back(t);
      end
    endfunction

    function void check_char(text_t got);
      text_t exp_t;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character transfer, expected none, actual %h last %b",
                 $time, got.character, got.last);
        errors++;
        return;
      end
      exp_t = expected_chars.pop_front();
      if (got.character !== exp_t.character) begin
        $display("%0t: character mismatch, expected %h actual %h",
                 $time, exp_t.character, got.character);
        errors++;
      end
      if (got.last !== exp_t.last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, exp_t.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_ready;
  item_t item = '0;
  logic  text_valid;
  logic  text_ready = 1'b0;
  text_t text;

  int idle_pct = 0;
  int stall_pct = 0;
  char_scoreboard sb = new();

  integer_to_ascii_formatter_unit #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    text_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) sb.note_item(item);
    if (!rst && text_valid && text_ready) sb.check_char(text);
  end

  // Valid stays high across back-to-back transfers; it only drops for a gap.
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_fields(input logic [63:0] v, input logic [1:0] act,
                             input logic sgn, input logic [6:0] w);
    item_t it;
    it.value = v;
    it.action = act;
    it.is_signed = sgn;
    it.digit_width = w;
    send_item(it);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] p;
    int k;
    p = 64'd1;
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(999));
      2: begin
        k = $urandom_range(19);
        repeat (k) p = p * 64'd10;
        return p - 64'($urandom_range(1));
      end
      3: return -64'($urandom_range(1000));
      4: return 64'h8000_0000_0000_0000 + 64'($urandom_range(20)) - 64'd10;
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    r = $urandom_range(99);
    it.value = random_value();
    it.action = r < 40 ? ACT_DECIMAL : r < 65 ? ACT_HEX : r < 92 ? ACT_BINARY : ACT_UNUSED;
    it.is_signed = 1'($urandom_range(1));
    r = $urandom_range(9);
    if (r < 8) it.digit_width = 7'($urandom_range(1, 64));
    else if (r == 8) it.digit_width = 7'($urandom_range(8));
    else it.digit_width = 7'($urandom_range(127));
    return it;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_fields(64'd0, ACT_DECIMAL, 1'b0, 7'd64);
    send_fields(64'hFFFF_FFFF_FFFF_FFFF, ACT_DECIMAL, 1'b0, 7'd0);
    send_fields(64'h8000_0000_0000_0000, ACT_DECIMAL, 1'b1, 7'd64);
    send_fields(64'h8000_0000_0000_0000, ACT_DECIMAL, 1'b0, 7'd64);
    send_fields(64'hFFFF_FFFF_FFFF_FFFF, ACT_DECIMAL, 1'b1, 7'd64);
    send_fields(64'h7FFF_FFFF_FFFF_FFFF, ACT_DECIMAL, 1'b1, 7'd64);
    send_fields(64'd12345, ACT_DECIMAL, 1'b1, 7'd127);
    send_fields(64'd9876543210, ACT_UNUSED, 1'b0, 7'd16);
    send_fields(-64'd42, ACT_UNUSED, 1'b1, 7'd1);
    send_fields(64'hFFFF_FFFF_FFFF_FFFF, ACT_HEX, 1'b0, 7'd64);
    send_fields(64'h0123_4567_89AB_CDEF, ACT_HEX, 1'b1, 7'd64);
    send_fields(64'h0000_0000_0000_000A, ACT_HEX, 1'b0, 7'd4);
    send_fields(64'h0000_0000_0000_0007, ACT_HEX, 1'b0, 7'd3);
    send_fields(64'hFFFF_FFFF_FFFF_FFFF, ACT_HEX, 1'b0, 7'd0);
    send_fields(64'h0000_0000_0000_00F5, ACT_HEX, 1'b0, 7'd7);
    send_fields(64'hFEDC_BA98_7654_3210, ACT_HEX, 1'b0, 7'd127);
    send_fields(64'hA5A5_5A5A_C3C3_3C3C, ACT_HEX, 1'b0, 7'd65);
    send_fields(64'hAAAA_5555_F0F0_0F0F, ACT_BINARY, 1'b0, 7'd64);
    send_fields(64'h0000_0000_0000_0001, ACT_BINARY, 1'b0, 7'd1);
    send_fields(64'hFFFF_FFFF_FFFF_FFFF, ACT_BINARY, 1'b0, 7'd0);
    send_fields(64'h8000_0000_0000_0001, ACT_BINARY, 1'b1, 7'd127);
    send_fields(64'h0000_0000_0000_0006, ACT_BINARY, 1'b1, 7'd5);
    send_fields(64'd0, ACT_BINARY, 1'b0, 7'd64);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      repeat (PHASE_ITEMS) send_item(random_item());
      drain();
    end

    $display("Covered %0d values (%0d with empty text) and %0d characters,",
             sb.items_noted, sb.silent_items, sb.chars_checked);
    $display("in decimal, hex and binary across four sender/receiver idle mixes.");
    if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d characters outstanding", sb.expected_chars.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
